@@ hw/rtl/gfrg_pkg.sv @@
// Package for the Gaussian fit residual and gradient unit.
// Holds shared types, constants and saturating fixed-point helpers.
// No dependencies.
package gfrg_pkg;

  localparam int FRAC = 16;
  localparam int BIN_W = 12;
  localparam int CNT_W = 24;
  localparam logic [15:0] LN2_Q = 16'd45426;
  localparam logic [19:0] Z_LIMIT = 20'd772242;
  localparam logic [16:0] ONE_Q = 17'h10000;

  localparam logic [2:0] REG_OFFSET = 3'd0;
  localparam logic [2:0] REG_AMPLITUDE = 3'd1;
  localparam logic [2:0] REG_CENTRE = 3'd2;
  localparam logic [2:0] REG_SPREAD = 3'd3;
  localparam logic [2:0] REG_FIRST_BIN = 3'd4;
  localparam logic [2:0] REG_FINAL_BIN = 3'd5;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic [BIN_W-1:0] bin;
    logic last;
  } item_t;

  typedef struct packed {
    logic [39:0] offset;
    logic [39:0] amplitude;
    logic [27:0] centre;
    logic [39:0] spread;
  } model_cfg_t;

  typedef struct packed {
    logic start;
    logic [63:0] a;
    logic [63:0] b;
  } mul_req_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic [127:0] p;
  } mul_rsp_t;

  typedef struct packed {
    logic start;
    logic [63:0] dividend;
    logic [39:0] divisor;
    logic [6:0] nbits;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic [63:0] q;
  } div_rsp_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_SQ, ST_Z, ST_RED, ST_EXPM, ST_EXPD, ST_AE, ST_AEW, ST_DV1, ST_DV2,
    ST_G, ST_SQE, ST_GE, ST_GA, ST_RAT, ST_GC, ST_Q2, ST_GS, ST_FIN
  } back_state_t;

  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) begin
      sat_add = s[64] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
    end else begin
      sat_add = s[63:0];
    end
  endfunction

  function automatic logic [63:0] mag(input logic [63:0] x);
    mag = x[63] ? (64'd0 - x) : x;
  endfunction

  function automatic logic [63:0] from_mag(input logic [63:0] m, input logic neg);
    if (neg) begin
      from_mag = m[63] ? 64'h8000_0000_0000_0000 : (64'd0 - m);
    end else begin
      from_mag = m[63] ? 64'h7FFF_FFFF_FFFF_FFFF : m;
    end
  endfunction

  function automatic logic [63:0] mulq_fin(input logic [127:0] p, input logic neg);
    logic [63:0] m;
    m = (|p[127:64+FRAC]) ? 64'hFFFF_FFFF_FFFF_FFFF : p[63+FRAC:FRAC];
    mulq_fin = from_mag(m, neg);
  endfunction

  // Division of a 16-bit value by 1 to 6 through reciprocal multiplication,
  // exact over the whole 16-bit range.
  function automatic logic [15:0] div_small(input logic [15:0] x, input logic [2:0] k);
    logic [33:0] p3, p5;
    p3 = {18'd0, x} * 34'd43691;
    p5 = {18'd0, x} * 34'd52429;
    case (k)
      3'd2: div_small = {1'b0, x[15:1]};
      3'd3: div_small = p3[32:17];
      3'd4: div_small = {2'b0, x[15:2]};
      3'd5: div_small = p5[33:18];
      3'd6: div_small = p3[33:18];
      default: div_small = x;
    endcase
  endfunction

endpackage

@@ hw/rtl/gfrg_front.sv @@
// Front end: accepts bin counts and tags each item with its bin index.
// Tracks the bin position of the pass. Uses gfrg_pkg.
module gfrg_front #(
  parameter int BIN_LIMIT = 4096
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic [gfrg_pkg::CNT_W-1:0] in_count,
  output logic in_ready,
  input  logic q_full,
  output logic q_push,
  output gfrg_pkg::item_t q_item,
  input  logic restart,
  input  logic [gfrg_pkg::BIN_W-1:0] restart_first,
  input  logic [gfrg_pkg::BIN_W-1:0] first_bin,
  input  logic [gfrg_pkg::BIN_W-1:0] final_bin
);

  localparam logic [gfrg_pkg::BIN_W-1:0] TOP = gfrg_pkg::BIN_W'(BIN_LIMIT - 1);

  logic [gfrg_pkg::BIN_W-1:0] bin_r, bin_nxt, first_c, final_c, restart_c;
  logic last;

  assign first_c = (first_bin > TOP) ? TOP : first_bin;
  assign final_c = (final_bin > TOP) ? TOP : final_bin;
  assign restart_c = (restart_first > TOP) ? TOP : restart_first;
  assign last = (bin_r == final_c);
  assign in_ready = !q_full;
  assign q_push = in_valid && !q_full;
  assign q_item = '{count: in_count, bin: bin_r, last: last};

  always_comb begin
    bin_nxt = bin_r;
    if (restart) begin
      bin_nxt = restart_c;
    end else if (q_push) begin
      if (last) begin
        bin_nxt = first_c;
      end else if (bin_r == TOP) begin
        bin_nxt = '0;
      end else begin
        bin_nxt = bin_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bin_r <= '0;
    end else begin
      bin_r <= bin_nxt;
    end
  end

endmodule

@@ hw/rtl/gfrg_queue.sv @@
// Two-entry queue between the front end and the back end.
// Uses gfrg_pkg for the item type.
module gfrg_queue (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  gfrg_pkg::item_t wr_item,
  output logic full,
  input  logic pop,
  output logic valid,
  output gfrg_pkg::item_t rd_item
);

  gfrg_pkg::item_t mem_r [2];
  logic wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full = (cnt_r == 2'd2);
  assign valid = (cnt_r != 2'd0);
  assign rd_item = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= !wp_r;
      end
      if (pop) begin
        rp_r <= !rp_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= wr_item;
    end
  end

endmodule

@@ hw/rtl/gfrg_mul.sv @@
// Shared 64x64 multiplier built from one 32x32 product per cycle.
// Four partial products are registered and accumulated. Uses gfrg_pkg.
module gfrg_mul (
  input  logic clk,
  input  logic rst_n,
  input  gfrg_pkg::mul_req_t req,
  output gfrg_pkg::mul_rsp_t rsp
);

  logic busy_r, done_r;
  logic [2:0] cnt_r;
  logic [1:0] sh_r;
  logic [63:0] a_r, b_r, prod_r;
  logic [127:0] acc_r;
  logic [31:0] ah, bh;

  assign ah = cnt_r[1] ? a_r[63:32] : a_r[31:0];
  assign bh = cnt_r[0] ? b_r[63:32] : b_r[31:0];
  assign rsp = '{busy: busy_r, done: done_r, p: acc_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == 3'd4) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      a_r <= req.a;
      b_r <= req.b;
      acc_r <= '0;
    end else if (busy_r) begin
      if (cnt_r != 3'd4) begin
        prod_r <= ah * bh;
        sh_r <= {1'b0, cnt_r[1]} + {1'b0, cnt_r[0]};
      end
      if (cnt_r != 3'd0) begin
        acc_r <= acc_r + ({64'd0, prod_r} << {sh_r, 5'd0});
      end
    end
  end

endmodule

@@ hw/rtl/gfrg_div.sv @@
// Shared restoring divider, one quotient bit per cycle.
// The caller gives the dividend width in bits. Uses gfrg_pkg.
module gfrg_div (
  input  logic clk,
  input  logic rst_n,
  input  gfrg_pkg::div_req_t req,
  output gfrg_pkg::div_rsp_t rsp
);

  logic busy_r, done_r;
  logic [6:0] cnt_r;
  logic [63:0] dvd_r, q_r;
  logic [39:0] dvs_r, rem_r;
  logic [40:0] rem_t;
  logic [5:0] idx;
  logic ge;

  assign idx = 6'(cnt_r - 7'd1);
  assign rem_t = {rem_r, dvd_r[idx]};
  assign ge = (rem_t >= {1'b0, dvs_r});
  assign rsp = '{busy: busy_r, done: done_r, q: q_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r <= req.nbits;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == 7'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd_r <= req.dividend;
      dvs_r <= req.divisor;
      rem_r <= '0;
      q_r <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? 40'(rem_t - {1'b0, dvs_r}) : rem_t[39:0];
      q_r <= {q_r[62:0], ge};
    end
  end

endmodule

@@ hw/rtl/gfrg_back.sv @@
// Back end: evaluates the model for one bin, updates the five sums (centre and
// spread if exponential nonzero); drives shared mul and divider, uses gfrg_pkg.
module gfrg_back (
  input  logic clk,
  input  logic rst_n,
  input  logic q_valid,
  input  gfrg_pkg::item_t q_item,
  output logic q_pop,
  input  gfrg_pkg::model_cfg_t cfg,
  input  logic restart,
  output gfrg_pkg::mul_req_t mul_req,
  input  gfrg_pkg::mul_rsp_t mul_rsp,
  output gfrg_pkg::div_req_t div_req,
  input  gfrg_pkg::div_rsp_t div_rsp,
  output logic out_valid,
  input  logic out_ready,
  output logic [319:0] out_data
);

  gfrg_pkg::back_state_t state_r, state_nxt;
  logic [23:0] cnt_r, cnt_nxt;
  logic last_r, last_nxt, ndx_r, ndx_nxt;
  logic [28:0] dm_r, dm_nxt;
  logic [55:0] z_r, z_nxt;
  logic [19:0] r_r, r_nxt;
  logic [4:0] n_r, n_nxt;
  logic [2:0] k_r, k_nxt;
  logic [16:0] h_r, h_nxt, e_r, e_nxt;
  logic [63:0] ae_r, ae_nxt, dv_r, dv_nxt, g_r, g_nxt, ga_r, ga_nxt;
  logic [63:0] err_r, err_nxt, aoff_r, aoff_nxt, aamp_r, aamp_nxt;
  logic [63:0] acen_r, acen_nxt, aspr_r, aspr_nxt;
  logic ov_r, ov_nxt;
  logic [319:0] od_r, od_nxt;
  logic [29:0] dx;
  logic [28:0] dm;
  logic [64:0] esum;
  logic [63:0] sqv, off, amag;
  logic [39:0] spr;

  function automatic logic [63:0] sqv_f(input logic [127:0] p);
    sqv_f = (|p[127:96]) ? 64'hFFFF_FFFF_FFFF_FFFF : p[95:32];
  endfunction

  assign spr = (cfg.spread == 40'd0) ? 40'd1 : cfg.spread;
  assign off = {{24{cfg.offset[39]}}, cfg.offset};
  assign amag = gfrg_pkg::mag({{24{cfg.amplitude[39]}}, cfg.amplitude});
  assign out_valid = ov_r;
  assign out_data = od_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r; last_nxt = last_r; ndx_nxt = ndx_r; dm_nxt = dm_r;
    z_nxt = z_r; r_nxt = r_r; n_nxt = n_r; k_nxt = k_r; h_nxt = h_r; e_nxt = e_r;
    ae_nxt = ae_r; dv_nxt = dv_r; g_nxt = g_r; ga_nxt = ga_r;
    err_nxt = err_r; aoff_nxt = aoff_r; aamp_nxt = aamp_r;
    acen_nxt = acen_r; aspr_nxt = aspr_r;
    ov_nxt = ov_r && !out_ready;
    od_nxt = od_r;
    q_pop = 1'b0;
    mul_req = '0;
    div_req = '0;
    dx = {2'b0, q_item.bin, 16'b0} - {2'b0, cfg.centre};
    dm = dx[29] ? 29'(30'd0 - dx) : dx[28:0];
    esum = {1'b0, err_r} + {1'b0, sqv_f(mul_rsp.p)};
    sqv = esum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : esum[63:0];
    case (state_r)
      gfrg_pkg::ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          cnt_nxt = q_item.count;
          last_nxt = q_item.last;
          ndx_nxt = dx[29];
          dm_nxt = dm;
          mul_req = '{start: 1'b1, a: {35'd0, dm}, b: {35'd0, dm}};
          state_nxt = gfrg_pkg::ST_SQ;
        end
      end
      gfrg_pkg::ST_SQ: begin
        if (mul_rsp.done) begin
          div_req = '{start: 1'b1, dividend: mul_rsp.p[63:0], divisor: spr, nbits: 7'd56};
          state_nxt = gfrg_pkg::ST_Z;
        end
      end
      gfrg_pkg::ST_Z: begin
        if (div_rsp.done) begin
          z_nxt = div_rsp.q[55:0];
          if (div_rsp.q >= {44'd0, gfrg_pkg::Z_LIMIT}) begin
            e_nxt = '0;
            state_nxt = gfrg_pkg::ST_AE;
          end else begin
            r_nxt = div_rsp.q[19:0];
            n_nxt = '0;
            state_nxt = gfrg_pkg::ST_RED;
          end
        end
      end
      gfrg_pkg::ST_RED: begin
        if (r_r >= {4'd0, gfrg_pkg::LN2_Q}) begin
          r_nxt = r_r - {4'd0, gfrg_pkg::LN2_Q};
          n_nxt = n_r + 1'b1;
        end else begin
          h_nxt = gfrg_pkg::ONE_Q;
          k_nxt = 3'd6;
          mul_req = '{start: 1'b1, a: {44'd0, r_r}, b: {47'd0, gfrg_pkg::ONE_Q}};
          state_nxt = gfrg_pkg::ST_EXPM;
        end
      end
      gfrg_pkg::ST_EXPM: begin
        if (mul_rsp.done) begin
          h_nxt = gfrg_pkg::ONE_Q - {1'b0, gfrg_pkg::div_small(mul_rsp.p[31:16], k_r)};
          state_nxt = gfrg_pkg::ST_EXPD;
        end
      end
      gfrg_pkg::ST_EXPD: begin
        if (k_r == 3'd1) begin
          e_nxt = h_r >> n_r;
          state_nxt = gfrg_pkg::ST_AE;
        end else begin
          k_nxt = k_r - 1'b1;
          mul_req = '{start: 1'b1, a: {44'd0, r_r}, b: {47'd0, h_r}};
          state_nxt = gfrg_pkg::ST_EXPM;
        end
      end
      gfrg_pkg::ST_AE: begin
        mul_req = '{start: 1'b1, a: amag, b: {47'd0, e_r}};
        state_nxt = gfrg_pkg::ST_AEW;
      end
      gfrg_pkg::ST_AEW: begin
        if (mul_rsp.done) begin
          ae_nxt = gfrg_pkg::mulq_fin(mul_rsp.p, cfg.amplitude[39]);
          state_nxt = gfrg_pkg::ST_DV1;
        end
      end
      gfrg_pkg::ST_DV1: begin
        dv_nxt = gfrg_pkg::sat_add(off, ae_r);
        state_nxt = gfrg_pkg::ST_DV2;
      end
      gfrg_pkg::ST_DV2: begin
        dv_nxt = gfrg_pkg::sat_add(dv_r, 64'd0 - {24'd0, cnt_r, 16'd0});
        state_nxt = gfrg_pkg::ST_G;
      end
      gfrg_pkg::ST_G: begin
        g_nxt = gfrg_pkg::sat_add(dv_r, dv_r);
        mul_req = '{start: 1'b1, a: gfrg_pkg::mag(dv_r), b: gfrg_pkg::mag(dv_r)};
        state_nxt = gfrg_pkg::ST_SQE;
      end
      gfrg_pkg::ST_SQE: begin
        if (mul_rsp.done) begin
          err_nxt = sqv;
          aoff_nxt = gfrg_pkg::sat_add(aoff_r, g_r);
          mul_req = '{start: 1'b1, a: gfrg_pkg::mag(g_r), b: {47'd0, e_r}};
          state_nxt = gfrg_pkg::ST_GE;
        end
      end
      gfrg_pkg::ST_GE: begin
        if (mul_rsp.done) begin
          aamp_nxt = gfrg_pkg::sat_add(aamp_r, gfrg_pkg::mulq_fin(mul_rsp.p, g_r[63]));
          if (e_r == 17'd0) begin
            state_nxt = gfrg_pkg::ST_FIN;
          end else begin
            mul_req = '{start: 1'b1, a: gfrg_pkg::mag(g_r), b: gfrg_pkg::mag(ae_r)};
            state_nxt = gfrg_pkg::ST_GA;
          end
        end
      end
      gfrg_pkg::ST_GA: begin
        if (mul_rsp.done) begin
          ga_nxt = gfrg_pkg::mulq_fin(mul_rsp.p, g_r[63] ^ ae_r[63]);
          div_req = '{start: 1'b1, dividend: {18'd0, dm_r, 17'd0}, divisor: spr,
                      nbits: 7'd46};
          state_nxt = gfrg_pkg::ST_RAT;
        end
      end
      gfrg_pkg::ST_RAT: begin
        if (div_rsp.done) begin
          mul_req = '{start: 1'b1, a: gfrg_pkg::mag(ga_r), b: div_rsp.q};
          state_nxt = gfrg_pkg::ST_GC;
        end
      end
      gfrg_pkg::ST_GC: begin
        if (mul_rsp.done) begin
          acen_nxt = gfrg_pkg::sat_add(acen_r,
                                       gfrg_pkg::mulq_fin(mul_rsp.p, ga_r[63] ^ ndx_r));
          div_req = '{start: 1'b1, dividend: {28'd0, z_r[19:0], 16'd0}, divisor: spr,
                      nbits: 7'd36};
          state_nxt = gfrg_pkg::ST_Q2;
        end
      end
      gfrg_pkg::ST_Q2: begin
        if (div_rsp.done) begin
          mul_req = '{start: 1'b1, a: gfrg_pkg::mag(ga_r), b: div_rsp.q};
          state_nxt = gfrg_pkg::ST_GS;
        end
      end
      gfrg_pkg::ST_GS: begin
        if (mul_rsp.done) begin
          aspr_nxt = gfrg_pkg::sat_add(aspr_r, gfrg_pkg::mulq_fin(mul_rsp.p, ga_r[63]));
          state_nxt = gfrg_pkg::ST_FIN;
        end
      end
      gfrg_pkg::ST_FIN: begin
        if (!last_r) begin
          state_nxt = gfrg_pkg::ST_IDLE;
        end else if (!ov_r || out_ready) begin
          ov_nxt = 1'b1;
          od_nxt = {aspr_r, acen_r, aamp_r, aoff_r, err_r};
          err_nxt = '0; aoff_nxt = '0; aamp_nxt = '0; acen_nxt = '0; aspr_nxt = '0;
          state_nxt = gfrg_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = gfrg_pkg::ST_IDLE;
      end
    endcase
    if (restart) begin
      err_nxt = '0; aoff_nxt = '0; aamp_nxt = '0; acen_nxt = '0; aspr_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gfrg_pkg::ST_IDLE;
      ov_r <= 1'b0;
      err_r <= '0; aoff_r <= '0; aamp_r <= '0; acen_r <= '0; aspr_r <= '0;
    end else begin
      state_r <= state_nxt;
      ov_r <= ov_nxt;
      err_r <= err_nxt; aoff_r <= aoff_nxt; aamp_r <= aamp_nxt;
      acen_r <= acen_nxt; aspr_r <= aspr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt; last_r <= last_nxt; ndx_r <= ndx_nxt; dm_r <= dm_nxt;
    z_r <= z_nxt; r_r <= r_nxt; n_r <= n_nxt; k_r <= k_nxt; h_r <= h_nxt; e_r <= e_nxt;
    ae_r <= ae_nxt; dv_r <= dv_nxt; g_r <= g_nxt; ga_r <= ga_nxt;
    od_r <= od_nxt;
  end

endmodule

@@ hw/rtl/gauss_fit_residual_gradient_unit.sv @@
// Gaussian fit residual and gradient unit, top level.
// The time a bin takes is set by the one-bit-per-cycle shared divider and the shared
// multiplier, and grows with the 0 to 16 range-reduction steps. The centre and spread
// terms are skipped when the exponential vanishes by range or its shifted result is zero.
// One bin is worked on at a time; the two-entry queue lets the input run ahead by two.
// The result follows the final bin after that bin's work, and waits in an output register.
// Synchronous active-low reset clears the sums and bin position; registers get defaults.
module gauss_fit_residual_gradient_unit #(
  parameter int BIN_COUNT_MAX = 4096
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  input  logic [23:0] in_tdata,   // bin_count
  output logic out_tvalid,
  input  logic out_tready,
  // error_sum, grad_offset, grad_amplitude, grad_centre, grad_spread (64 bits each)
  output logic [319:0] out_tdata,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [39:0] cfg_data
);

  localparam int BIN_LIMIT = (BIN_COUNT_MAX < 4096) ? BIN_COUNT_MAX : 4096;

  gfrg_pkg::model_cfg_t cfg_r;
  logic [11:0] first_r, final_r, restart_first;
  logic cfg_wr, restart, q_full, q_push, q_pop, q_valid;
  gfrg_pkg::item_t wr_item, rd_item;
  gfrg_pkg::mul_req_t mul_req;
  gfrg_pkg::mul_rsp_t mul_rsp;
  gfrg_pkg::div_req_t div_req;
  gfrg_pkg::div_rsp_t div_rsp;

  assign cfg_ready = 1'b1;
  assign cfg_wr = cfg_valid && cfg_ready;
  assign restart = cfg_wr && (cfg_index == gfrg_pkg::REG_FIRST_BIN ||
                              cfg_index == gfrg_pkg::REG_FINAL_BIN);
  assign restart_first = (cfg_index == gfrg_pkg::REG_FIRST_BIN) ? cfg_data[11:0] : first_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{offset: '0, amplitude: '0, centre: '0, spread: 40'd65536};
      first_r <= 12'd0;
      final_r <= 12'd4095;
    end else if (cfg_wr) begin
      case (cfg_index)
        gfrg_pkg::REG_OFFSET: cfg_r.offset <= cfg_data;
        gfrg_pkg::REG_AMPLITUDE: cfg_r.amplitude <= cfg_data;
        gfrg_pkg::REG_CENTRE: cfg_r.centre <= cfg_data[27:0];
        gfrg_pkg::REG_SPREAD: cfg_r.spread <= cfg_data;
        gfrg_pkg::REG_FIRST_BIN: first_r <= cfg_data[11:0];
        gfrg_pkg::REG_FINAL_BIN: final_r <= cfg_data[11:0];
        default: begin
        end
      endcase
    end
  end

  gfrg_front #(.BIN_LIMIT(BIN_LIMIT)) u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_tvalid), .in_count(in_tdata),
    .in_ready(in_tready), .q_full(q_full), .q_push(q_push), .q_item(wr_item),
    .restart(restart), .restart_first(restart_first), .first_bin(first_r),
    .final_bin(final_r)
  );

  gfrg_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(q_push), .wr_item(wr_item), .full(q_full),
    .pop(q_pop), .valid(q_valid), .rd_item(rd_item)
  );

  gfrg_mul u_mul (.clk(clk), .rst_n(rst_n), .req(mul_req), .rsp(mul_rsp));

  gfrg_div u_div (.clk(clk), .rst_n(rst_n), .req(div_req), .rsp(div_rsp));

  gfrg_back u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_item(rd_item), .q_pop(q_pop),
    .cfg(cfg_r), .restart(restart), .mul_req(mul_req), .mul_rsp(mul_rsp),
    .div_req(div_req), .div_rsp(div_rsp), .out_valid(out_tvalid),
    .out_ready(out_tready), .out_data(out_tdata)
  );

  a_mul_free: assert property (@(posedge clk) disable iff (!rst_n)
    mul_req.start |-> !mul_rsp.busy) else $error("multiplier started while busy");

  a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> !div_rsp.busy) else $error("divider started while busy");

  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> div_req.divisor != 40'd0) else $error("divide by zero");

  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid) else $error("queue popped while empty");

endmodule

@@ tb/tb_gauss_fit_residual_gradient_unit.sv @@
// Self-checking testbench for the Gaussian fit residual and gradient unit.
// Streams bin counts over passes under many model settings and checks each pass result
// against an in-bench fixed-point predictor. Depends on gfrg_pkg and the unit's RTL.
`timescale 1ns / 100ps

module tb_gauss_fit_residual_gradient_unit;

  localparam int STALL_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 1000;
  localparam logic [63:0] S_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] S_MIN = 64'h8000_0000_0000_0000;
  localparam logic [63:0] U_MAX = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic [63:0] spread_grad;
    logic [63:0] centre_grad;
    logic [63:0] amp_grad;
    logic [63:0] offset_grad;
    logic [63:0] err;
  } fit_sums_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [23:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [319:0] out_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [39:0] cfg_data = '0;

  gauss_fit_residual_gradient_unit dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Predictor copy of the registers and running sums.
  logic [39:0] p_offset, p_amplitude, p_spread;
  logic [27:0] p_centre;
  logic [11:0] p_first, p_final, p_pos;
  fit_sums_t p_sums;

  logic [23:0] count_feed[$];
  fit_sums_t pass_results[$];
  int n_fail = 0;
  bit calm = 1'b0;
  bit hold_req = 1'b0;
  bit feed_pause = 1'b0;

  function automatic logic [63:0] abs64(input logic [63:0] x);
    return x[63] ? -x : x;
  endfunction

  function automatic logic [63:0] signed_of(input logic [63:0] m, input bit neg);
    if (neg) return (m >= S_MIN) ? S_MIN : -m;
    return (m > S_MAX) ? S_MAX : m;
  endfunction

  function automatic logic [63:0] add_sat(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) return s[64] ? S_MIN : S_MAX;
    return s[63:0];
  endfunction

  function automatic logic [63:0] qmul(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] wa, wb, p;
    wa = {64'd0, abs64(a)};
    wb = {64'd0, abs64(b)};
    p = (wa * wb) >> gfrg_pkg::FRAC;
    return signed_of((|p[127:64]) ? U_MAX : p[63:0], a[63] != b[63]);
  endfunction

  function automatic logic [63:0] exp_approx(input logic [63:0] z);
    logic [63:0] n, r, h;
    n = z / 64'd45426;
    if (n > 64'd16) return 64'd0;
    r = z - n * 64'd45426;
    h = 64'd65536;
    for (int k = 6; k >= 1; k--) h = 64'd65536 - ((r * h) >> gfrg_pkg::FRAC) / k;
    return h >> n;
  endfunction

  function automatic void clear_pass();
    p_pos = p_first;
    p_sums = '0;
  endfunction

  function automatic void set_reg(input logic [2:0] idx, input logic [39:0] v);
    case (idx)
      gfrg_pkg::REG_OFFSET: p_offset = v;
      gfrg_pkg::REG_AMPLITUDE: p_amplitude = v;
      gfrg_pkg::REG_CENTRE: p_centre = v[27:0];
      gfrg_pkg::REG_SPREAD: p_spread = v;
      gfrg_pkg::REG_FIRST_BIN: begin p_first = v[11:0]; clear_pass(); end
      gfrg_pkg::REG_FINAL_BIN: begin p_final = v[11:0]; clear_pass(); end
      default: ;
    endcase
  endfunction

  // Folds one bin into the sums; returns 1 with the pass sums when the final bin is taken.
  function automatic bit fold_bin(input logic [23:0] cnt, output fit_sums_t res);
    logic [63:0] dx, dm, z, e, ae, dv, g, ga, ratio, q2, sq, spr, off, amp;
    logic [127:0] w, wd;
    logic [64:0] esum;
    spr = (p_spread == 0) ? 64'd1 : {24'd0, p_spread};
    off = {{24{p_offset[39]}}, p_offset};
    amp = {{24{p_amplitude[39]}}, p_amplitude};
    dx = {36'd0, p_pos, 16'd0} - {36'd0, p_centre};
    dm = abs64(dx);
    wd = {64'd0, dm};
    w = (wd * wd) / {64'd0, spr};
    z = (|w[127:64]) ? U_MAX : w[63:0];
    e = exp_approx(z);
    ae = qmul(amp, e);
    dv = add_sat(add_sat(off, ae), -{24'd0, cnt, 16'd0});
    wd = {64'd0, abs64(dv)};
    w = wd * wd;
    sq = (|w[127:96]) ? U_MAX : w[95:32];
    esum = {1'b0, p_sums.err} + {1'b0, sq};
    p_sums.err = esum[64] ? U_MAX : esum[63:0];
    g = add_sat(dv, dv);
    p_sums.offset_grad = add_sat(p_sums.offset_grad, g);
    p_sums.amp_grad = add_sat(p_sums.amp_grad, qmul(g, e));
    if (e != 0) begin
      ga = qmul(g, ae);
      ratio = signed_of((dm << (gfrg_pkg::FRAC + 1)) / spr, dx[63]);
      q2 = (z << gfrg_pkg::FRAC) / spr;
      p_sums.centre_grad = add_sat(p_sums.centre_grad, qmul(ga, ratio));
      p_sums.spread_grad = add_sat(p_sums.spread_grad, qmul(ga, q2));
    end
    res = p_sums;
    if (p_pos == p_final) begin
      clear_pass();
      return 1'b1;
    end
    p_pos = p_pos + 12'd1;
    return 1'b0;
  endfunction

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 20);
    return $urandom_range(50, 400);
  endfunction

  // Driver: offers counts from the feed queue and predicts each accepted item.
  bit in_took = 1'b0;
  int in_gap = 0;
  always @(posedge clk) begin
    fit_sums_t res;
    in_took <= in_tvalid && in_tready;
    if (in_tvalid && in_tready && fold_bin(in_tdata, res)) pass_results.push_back(res);
  end

  always @(negedge clk) begin
    if (!in_tvalid || in_took) begin
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_tvalid <= 1'b0;
      end else if (count_feed.size() > 0 && !feed_pause) begin
        in_tdata <= count_feed.pop_front();
        in_tvalid <= 1'b1;
        in_gap <= pick_gap();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls plus one long hold-off on request.
  int out_stall = 0;
  bit hold_taken = 1'b0;
  always @(negedge clk) begin
    if (hold_req && !hold_taken) begin
      hold_taken <= 1'b1;
      out_stall <= 3000;
      out_tready <= 1'b0;
    end else if (out_stall > 0) begin
      out_stall <= out_stall - 1;
      out_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 3) == 0) begin
      out_stall <= pick_gap();
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    fit_sums_t got, want;
    if (out_tvalid && out_tready) begin
      got = out_tdata;
      if (pass_results.size() == 0) begin
        $error("pass result with none expected: %h", out_tdata);
        n_fail++;
      end else begin
        want = pass_results.pop_front();
        if (got.err !== want.err) begin
          $error("error_sum expected %0d got %0d", want.err, got.err);
          n_fail++;
        end
        if (got.offset_grad !== want.offset_grad) begin
          $error("grad_offset expected %0d got %0d",
                 $signed(want.offset_grad), $signed(got.offset_grad));
          n_fail++;
        end
        if (got.amp_grad !== want.amp_grad) begin
          $error("grad_amplitude expected %0d got %0d",
                 $signed(want.amp_grad), $signed(got.amp_grad));
          n_fail++;
        end
        if (got.centre_grad !== want.centre_grad) begin
          $error("grad_centre expected %0d got %0d",
                 $signed(want.centre_grad), $signed(got.centre_grad));
          n_fail++;
        end
        if (got.spread_grad !== want.spread_grad) begin
          $error("grad_spread expected %0d got %0d",
                 $signed(want.spread_grad), $signed(got.spread_grad));
          n_fail++;
        end
      end
    end
  end

  int quiet = 0;
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet >= STALL_LIMIT) begin
      $display("tb_gauss_fit_residual_gradient_unit failed");
      $finish;
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [39:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    set_reg(idx, v);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic settle();
    wait (count_feed.size() == 0 && !in_tvalid && pass_results.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_model(input logic [39:0] off, input logic [39:0] amp,
                           input logic [27:0] ctr, input logic [39:0] spr);
    write_reg(gfrg_pkg::REG_OFFSET, off);
    write_reg(gfrg_pkg::REG_AMPLITUDE, amp);
    write_reg(gfrg_pkg::REG_CENTRE, {12'd0, ctr});
    write_reg(gfrg_pkg::REG_SPREAD, spr);
  endtask

  task automatic set_bins(input logic [11:0] lo, input logic [11:0] hi);
    write_reg(gfrg_pkg::REG_FIRST_BIN, {28'd0, lo});
    write_reg(gfrg_pkg::REG_FINAL_BIN, {28'd0, hi});
  endtask

  function automatic logic [23:0] rand_count();
    case ($urandom_range(0, 5))
      0: return 24'd0;
      1: return 24'hFF_FFFF;
      2: return 24'($urandom_range(0, 255));
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic logic [39:0] rand40();
    return {$urandom, $urandom};
  endfunction

  task automatic push_counts(input int n);
    repeat (n) count_feed.push_back(rand_count());
  endtask

  initial begin
    int len, n_items;
    logic [11:0] lo;
    set_reg(gfrg_pkg::REG_OFFSET, 40'd0);
    set_reg(gfrg_pkg::REG_AMPLITUDE, 40'd0);
    set_reg(gfrg_pkg::REG_CENTRE, 40'd0);
    set_reg(gfrg_pkg::REG_SPREAD, 40'd65536);
    set_reg(gfrg_pkg::REG_FIRST_BIN, 40'd0);
    set_reg(gfrg_pkg::REG_FINAL_BIN, 40'd4095);
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: a peak near bin 3, extreme counts, single bin, wrapping pass.
    set_model(40'd10 << 16, 40'd1000 << 16, 28'd3 << 16, 40'd4 << 16);
    set_bins(12'd0, 12'd5);
    count_feed.push_back(24'd0);
    count_feed.push_back(24'hFF_FFFF);
    count_feed.push_back(24'd500);
    count_feed.push_back(24'd1000);
    count_feed.push_back(24'hAA_AAAA);
    count_feed.push_back(24'h55_5555);
    settle();
    // Zero spread, extreme parameters, centre at its top, ignored indexes.
    set_model(40'h7F_FFFF_FFFF, 40'h80_0000_0000, 28'hFFF_FFFF, 40'd0);
    write_reg(3'd6, 40'hFF_FFFF_FFFF);
    write_reg(3'd7, 40'hFF_FFFF_FFFF);
    set_bins(12'd4095, 12'd4095);
    push_counts(2);
    settle();
    set_model(40'h80_0000_0000, 40'h7F_FFFF_FFFF, 28'd4095 << 16, 40'hFF_FFFF_FFFF);
    set_bins(12'd4094, 12'd1);
    push_counts(4);
    settle();
    // Vanishing exponential: centre far from the bins, narrow width.
    set_model(40'd5 << 16, 40'd200 << 16, 28'd2000 << 16, 40'd1);
    set_bins(12'd10, 12'd12);
    push_counts(3);
    settle();

    // Long receiver hold-off while single-bin passes keep arriving.
    set_model(40'd1 << 16, 40'd50 << 16, 28'd7 << 16, 40'd8 << 16);
    set_bins(12'd7, 12'd7);
    hold_req = 1'b1;
    push_counts(12);
    settle();

    n_items = 0;
    while (n_items < 750) begin
      calm = ($urandom_range(0, 5) == 0);
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 16) : $urandom_range(1, 6);
      lo = 12'($urandom);
      case ($urandom_range(0, 4))
        0: set_model(rand40(), rand40(), 28'($urandom), rand40());
        1: set_model(40'd0, 40'd0, 28'd0, 40'd0);
        default: set_model({{8{1'b0}}, $urandom_range(0, 32'h3FFF_FFFF)} - (40'd1 << 29),
                           rand40() >> $urandom_range(0, 16),
                           28'(({16'd0, lo} << 16) + $urandom_range(0, len << 16)),
                           40'($urandom_range(1, 64 << 16)));
      endcase
      set_bins(lo, 12'(lo + len - 1));
      repeat ($urandom_range(1, 5)) begin
        push_counts(len);
        n_items += len;
      end
      if ($urandom_range(0, 4) == 0 && len > 1) begin
        push_counts(len - 1);
        n_items += len - 1;
      end
      if ($urandom_range(0, 7) == 0) begin
        feed_pause = 1'b1;
        wait (!in_tvalid && pass_results.size() == 0);
        feed_pause = 1'b0;
      end
      settle();
    end

    wait (count_feed.size() == 0 && !in_tvalid && pass_results.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (n_fail == 0) begin
      $display("tb_gauss_fit_residual_gradient_unit passed");
    end else begin
      $display("tb_gauss_fit_residual_gradient_unit failed");
    end
    $finish;
  end

endmodule
